### hw/rtl/gww_pkg.sv
package gww_pkg;

  localparam int CHAR_W  = 8;
  localparam int GLYPH_W = 16;
  localparam int WIDTH_W = 24;
  localparam int POS_W   = 32;
  localparam int ID_W    = 32;
  localparam int VER_W   = 16;
  localparam int IDX_W   = 16;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WRAP_LIMIT = 1'b0,
    REG_BLANK_W    = 1'b1
  } cfg_reg_t;

  localparam logic [WIDTH_W-1:0] WRAP_LIMIT_RST = 24'd204800;
  localparam logic [GLYPH_W-1:0] BLANK_W_RST    = 16'd2048;
  localparam logic [WIDTH_W-1:0] WIDTH_SAT      = 24'hFFFFFF;
  localparam logic [IDX_W-1:0]   IDX_SAT        = 16'hFFFF;

  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_NL    = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

  typedef struct packed {
    logic [CHAR_W-1:0]  char_code;
    logic [GLYPH_W-1:0] glyph_width;
    logic [POS_W-1:0]   char_pos;
    logic [ID_W-1:0]    line_id;
    logic [VER_W-1:0]   line_rev;
    logic               end_of_line;
    logic               empty_line;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0]    out_line_id;
    logic [VER_W-1:0]   out_version;
    logic [POS_W-1:0]   first_pos;
    logic [POS_W-1:0]   end_pos;
    logic [IDX_W-1:0]   row_index;
    logic [WIDTH_W-1:0] row_width;
    logic               last;
  } out_item_t;

  function automatic logic is_break_char(input logic [CHAR_W-1:0] c);
    return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_NL) || (c == CHAR_NUL);
  endfunction

endpackage

### hw/rtl/gww_stream_if.sv
interface gww_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### hw/rtl/gww_div.sv
module gww_div
  import gww_pkg::*;
#(
  parameter int MOD = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [WIDTH_W-1:0]           dividend,
  input  logic [GLYPH_W-1:0]           divisor,
  output logic                         done,
  output logic [$clog2(MOD+1)-1:0]     rem_mod
);

  localparam int MW    = $clog2(MOD+1);
  localparam int CNT_W = $clog2(WIDTH_W+1);
  localparam logic [MW:0] MOD_C = (MW+1)'(MOD);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [GLYPH_W-1:0] acc;
  logic [WIDTH_W-1:0] shreg;
  logic [GLYPH_W-1:0] dsr;

  logic [GLYPH_W:0]   trial;
  logic [GLYPH_W:0]   diff;
  logic               qbit;
  logic [GLYPH_W-1:0] acc_next;
  logic [MW:0]        m2;
  logic [MW-1:0]      rem_mod_next;

  always_comb begin
    trial    = {acc, shreg[WIDTH_W-1]};
    diff     = trial - {1'b0, dsr};
    qbit     = trial >= {1'b0, dsr};
    acc_next = qbit ? diff[GLYPH_W-1:0] : trial[GLYPH_W-1:0];
    // running quotient modulo MOD, one quotient bit per step
    m2 = {rem_mod, qbit};
    if (m2 >= MOD_C) begin
      rem_mod_next = MW'(m2 - MOD_C);
    end else begin
      rem_mod_next = MW'(m2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(WIDTH_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc     <= '0;
      shreg   <= dividend;
      dsr     <= divisor;
      rem_mod <= '0;
    end else if (busy) begin
      acc     <= acc_next;
      shreg   <= {shreg[WIDTH_W-2:0], 1'b0};
      rem_mod <= rem_mod_next;
    end
  end

endmodule

### hw/rtl/greedy_word_wrap.sv
// Greedy word wrap: takes one text byte per word with its glyph width and position and
// emits up to three visual-line words per byte (break before, forced break, end of line).
// Each try passes through the try and evaluate states, and each byte also through accept,
// finish and flush; on each try a tab also runs the restoring divider (one quotient bit per
// cycle over 24 bits) to find the current column modulo the tab stop. A byte can take up to
// three tries. Result words leave through an output register and stall on its handshake.
// Configuration writes take effect at once and are meant for idle periods only.
module greedy_word_wrap
  import gww_pkg::*;
#(
  parameter int TAB_STOP = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  gww_stream_if.sink            in_ch,
  gww_stream_if.source          out_ch
);

  localparam int TW    = $clog2(TAB_STOP+1);
  localparam int CW_W  = GLYPH_W + TW;
  localparam int SUM_W = WIDTH_W + 1;
  localparam logic [TW-1:0] TAB_C = TW'(TAB_STOP);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_TRY   = 6'b000010,
    S_DIV   = 6'b000100,
    S_EVAL  = 6'b001000,
    S_FIN   = 6'b010000,
    S_FLUSH = 6'b100000
  } state_t;

  state_t state;

  logic [WIDTH_W-1:0] wrap_limit;
  logic [GLYPH_W-1:0] blank_w;

  logic [POS_W-1:0]   line_start_pos;
  logic [WIDTH_W-1:0] line_width;
  logic [POS_W-1:0]   break_pos;
  logic [WIDTH_W-1:0] width_after_break;
  logic [IDX_W-1:0]   visual_counter;
  logic               line_open;

  logic [CHAR_W-1:0]  c;
  logic [GLYPH_W-1:0] gw;
  logic [POS_W-1:0]   pos;
  logic [ID_W-1:0]    id;
  logic [VER_W-1:0]   ver;
  logic               eol;
  logic [CW_W-1:0]    cw;
  logic [1:0]         tries;

  out_item_t pend;
  logic      pend_valid;
  out_item_t out_data;
  logic      out_valid;
  logic      out_load;
  out_item_t out_word;

  logic               div_start;
  logic               div_done;
  logic [TW-1:0]      div_rem;
  logic [TW-1:0]      tab_diff;
  logic [CW_W-1:0]    tab_w;

  logic               is_tab;
  logic [SUM_W-1:0]   sum;
  logic [SUM_W-1:0]   wab_sum;
  logic [WIDTH_W-1:0] lw_sat;
  logic [WIDTH_W-1:0] wab_sat;
  logic               over;
  logic               has_break;
  logic [WIDTH_W-1:0] brk_w;
  logic [IDX_W-1:0]   vc_inc;
  logic [POS_W-1:0]   pos_inc;
  logic [POS_W-1:0]   new_start;
  logic               slot_free;
  logic               can_commit;
  out_item_t          res_break;
  out_item_t          res_eol;
  out_item_t          res_empty;

  gww_div #(
    .MOD (TAB_STOP)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (line_width),
    .divisor  (blank_w),
    .done     (div_done),
    .rem_mod  (div_rem)
  );

  always_comb begin
    is_tab    = c == CHAR_TAB;
    div_start = (state == S_TRY) && is_tab && (blank_w != '0);
    tab_diff  = TAB_C - div_rem;
    tab_w     = CW_W'(tab_diff) * CW_W'(blank_w);

    sum     = {1'b0, line_width} + SUM_W'(cw);
    wab_sum = {1'b0, width_after_break} + SUM_W'(cw);
    lw_sat  = sum[WIDTH_W] ? WIDTH_SAT : sum[WIDTH_W-1:0];
    wab_sat = wab_sum[WIDTH_W] ? WIDTH_SAT : wab_sum[WIDTH_W-1:0];
    over    = (sum > {1'b0, wrap_limit}) && (pos != line_start_pos) && (tries != 2'd2);

    has_break = break_pos != line_start_pos;
    brk_w     = (line_width >= width_after_break) ? line_width - width_after_break : '0;
    vc_inc    = (visual_counter == IDX_SAT) ? visual_counter : visual_counter + 1'b1;
    pos_inc   = pos + 1'b1;
    new_start = has_break ? break_pos : pos;

    res_break.out_line_id = id;
    res_break.out_version = ver;
    res_break.first_pos   = line_start_pos;
    res_break.end_pos     = new_start;
    res_break.row_index   = visual_counter;
    res_break.row_width   = has_break ? brk_w : line_width;
    res_break.last        = 1'b0;

    res_eol.out_line_id = id;
    res_eol.out_version = ver;
    res_eol.first_pos   = line_start_pos;
    res_eol.end_pos     = pos_inc;
    res_eol.row_index   = visual_counter;
    res_eol.row_width   = line_width;
    res_eol.last        = 1'b0;

    res_empty.out_line_id = in_ch.payload.line_id;
    res_empty.out_version = in_ch.payload.line_rev;
    res_empty.first_pos   = in_ch.payload.char_pos;
    res_empty.end_pos     = in_ch.payload.char_pos;
    res_empty.row_index   = '0;
    res_empty.row_width   = '0;
    res_empty.last        = 1'b0;

    slot_free  = !out_valid || out_ch.ready;
    can_commit = !pend_valid || slot_free;

    out_load = pend_valid && slot_free &&
               (((state == S_EVAL) && over) || ((state == S_FIN) && eol) ||
                (state == S_FLUSH));
    out_word      = pend;
    out_word.last = state == S_FLUSH;
  end

  assign in_ch.ready    = state == S_IDLE;
  assign out_ch.valid   = out_valid;
  assign out_ch.payload = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
      out_data  <= out_word;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      pend_valid        <= 1'b0;
      wrap_limit        <= WRAP_LIMIT_RST;
      blank_w           <= BLANK_W_RST;
      line_start_pos    <= '0;
      line_width        <= '0;
      break_pos         <= '0;
      width_after_break <= '0;
      visual_counter    <= '0;
      line_open         <= 1'b0;
      tries             <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_WRAP_LIMIT: wrap_limit <= cfg_data[WIDTH_W-1:0];
          REG_BLANK_W:    blank_w    <= cfg_data[GLYPH_W-1:0];
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            c     <= in_ch.payload.char_code;
            gw    <= in_ch.payload.glyph_width;
            pos   <= in_ch.payload.char_pos;
            id    <= in_ch.payload.line_id;
            ver   <= in_ch.payload.line_rev;
            eol   <= in_ch.payload.end_of_line;
            tries <= '0;
            if (in_ch.payload.empty_line) begin
              pend              <= res_empty;
              pend_valid        <= 1'b1;
              line_open         <= 1'b0;
              visual_counter    <= '0;
              line_width        <= '0;
              width_after_break <= '0;
              line_start_pos    <= in_ch.payload.char_pos;
              break_pos         <= in_ch.payload.char_pos;
              state             <= S_FLUSH;
            end else begin
              if (!line_open) begin
                line_open         <= 1'b1;
                line_start_pos    <= in_ch.payload.char_pos;
                break_pos         <= in_ch.payload.char_pos;
                line_width        <= '0;
                width_after_break <= '0;
                visual_counter    <= '0;
              end
              state <= S_TRY;
            end
          end
        end
        S_TRY: begin
          if (div_start) begin
            state <= S_DIV;
          end else begin
            cw    <= is_tab ? '0 : CW_W'(gw);
            state <= S_EVAL;
          end
        end
        S_DIV: begin
          if (div_done) begin
            cw    <= tab_w;
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (over) begin
            if (can_commit) begin
              pend              <= res_break;
              pend_valid        <= 1'b1;
              line_start_pos    <= new_start;
              break_pos         <= new_start;
              line_width        <= has_break ? width_after_break : '0;
              width_after_break <= '0;
              visual_counter    <= vc_inc;
              tries             <= tries + 1'b1;
              state             <= S_TRY;
            end
          end else begin
            line_width <= lw_sat;
            if (is_break_char(c)) begin
              break_pos         <= pos_inc;
              width_after_break <= '0;
            end else begin
              width_after_break <= wab_sat;
            end
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!eol) begin
            state <= S_FLUSH;
          end else if (can_commit) begin
            pend           <= res_eol;
            pend_valid     <= 1'b1;
            line_open      <= 1'b0;
            visual_counter <= '0;
            state          <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          if (!pend_valid) begin
            state <= S_IDLE;
          end else if (slot_free) begin
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst) (state == S_IDLE) |-> !pend_valid)
    else $error("held word left over while idle");
  assert property (@(posedge clk) disable iff (rst) tries != 2'd3)
    else $error("more than two forced breaks on one byte");
  assert property (@(posedge clk) disable iff (rst) div_done |-> (state == S_DIV))
    else $error("divider finished outside a tab measurement");
  assert property (@(posedge clk) disable iff (rst)
      (out_valid && !out_ch.ready && pend_valid) |=> (out_data == $past(out_data)))
    else $error("stalled output word overwritten");
`endif

endmodule
